// ----- src/pcf_pkg.sv -----
// shared types and constants for the polyphase complex fir filter
`timescale 1ns / 1ps
`default_nettype none
package pcf_pkg;
  localparam int TAPS = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEFF_WIDTH = 16;
  localparam int ACC_WIDTH = 52;
  localparam int OUT_WIDTH = 16;
  localparam int MAX_RATE = 16;
  localparam int TAP_BITS = $clog2(TAPS);
  localparam int RATE_BITS = $clog2(MAX_RATE + 1);
  localparam int PROD_WIDTH = SAMPLE_WIDTH + COEFF_WIDTH;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEFF = 1'b1;

  localparam logic [1:0] REG_RATE = 2'd0;
  localparam logic [1:0] REG_TAPS = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  // one queued job for the back end
  typedef struct packed {
    logic [RATE_BITS-1:0] phases;
    logic [RATE_BITS-1:0] step;
  } job_t;

  function automatic logic signed [OUT_WIDTH-1:0] finish(
      input logic signed [ACC_WIDTH-1:0] acc, input logic [5:0] s);
    logic signed [ACC_WIDTH:0] q;
    logic signed [ACC_WIDTH:0] omax;
    logic signed [ACC_WIDTH:0] omin;
    logic rb;
    begin
      q = (ACC_WIDTH + 1)'(acc >>> s);
      rb = (s == 6'd0) ? 1'b0 : ((s - 6'd1) >= 6'(ACC_WIDTH) ? acc[ACC_WIDTH-1]
                                 : acc[s - 6'd1]);
      q = q + (ACC_WIDTH + 1)'(rb);
      omax = (ACC_WIDTH + 1)'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
      omin = -omax - 1;
      if (q > omax) q = omax;
      if (q < omin) q = omin;
      finish = q[OUT_WIDTH-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- src/pcf_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/pcf_front.sv -----
// front end: coefficient and delay writes, job classification
`timescale 1ns / 1ps
`default_nettype none
module pcf_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic                          back_busy,
  input  wire logic                          q_full,
  output logic                               q_push,
  output pcf_pkg::job_t                      q_job,
  output logic                               coef_we,
  output logic                               dly_we,
  input  wire logic signed [5:0]             rate_change
);
  import pcf_pkg::*;
  logic [4:0] decimation_count;
  logic signed [6:0] r;
  logic [RATE_BITS-1:0] mag;
  logic accept;
  logic is_dec;
  logic fire;

  // delay memory is rewritten while back end reads it, so a sample waits for idle
  assign in_ready = !q_full && !back_busy;
  assign accept = in_valid && in_ready;
  assign coef_we = accept && cmd == CMD_COEFF;
  assign dly_we = accept && cmd == CMD_SAMPLE;

  always_comb begin
    r = 7'(rate_change);
    if (r > 7'(MAX_RATE)) r = 7'(MAX_RATE);
    if (r < -7'(MAX_RATE)) r = -7'(MAX_RATE);
    mag = (r < 0) ? RATE_BITS'(-r) : RATE_BITS'(r);
    is_dec = r < -7'sd1;
    fire = !is_dec || (5'(decimation_count + 5'd1) >= 5'(mag)) ||
           (decimation_count == 5'd31);
    q_job.phases = (r > 7'sd1) ? mag : RATE_BITS'(1);
    q_job.step = (r > 7'sd1) ? mag : RATE_BITS'(1);
  end
  assign q_push = dly_we && fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_count <= '0;
    end else if (dly_we) begin
      decimation_count <= (is_dec && !fire) ? decimation_count + 5'd1 : 5'd0;
    end
  end
endmodule
`default_nettype wire

// ----- src/pcf_back.sv -----
// back end: multiply-accumulate sequencer over phases and taps
`timescale 1ns / 1ps
`default_nettype none
module pcf_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire pcf_pkg::job_t              q_job,
  output logic                            q_pop,
  output logic                            busy,
  input  wire logic [6:0]                 tap_count,
  input  wire logic [5:0]                 output_shift,
  output logic [pcf_pkg::TAP_BITS-1:0]    c_addr,
  output logic [pcf_pkg::TAP_BITS-1:0]    d_addr,
  input  wire logic [pcf_pkg::COEFF_WIDTH-1:0] c_data,
  input  wire logic [2*pcf_pkg::SAMPLE_WIDTH-1:0] d_data,
  output logic                            m_valid,
  input  wire logic                       m_ready,
  output logic [2*pcf_pkg::OUT_WIDTH:0]   m_data
);
  import pcf_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;
  job_t job;
  logic [RATE_BITS-1:0] phase;
  logic [TAP_BITS:0] idx;
  logic [TAP_BITS:0] k;
  logic [TAP_BITS:0] n;
  logic rd_v, mul_v;
  logic signed [PROD_WIDTH-1:0] p_re, p_im;
  logic signed [ACC_WIDTH-1:0] acc_re, acc_im;
  logic last_phase;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] a, input logic signed [PROD_WIDTH-1:0] b);
    logic signed [ACC_WIDTH+PROD_WIDTH:0] s;
    logic signed [ACC_WIDTH+PROD_WIDTH:0] mx;
    begin
      s = (ACC_WIDTH + PROD_WIDTH + 1)'(a) + (ACC_WIDTH + PROD_WIDTH + 1)'(b);
      mx = (ACC_WIDTH + PROD_WIDTH + 1)'({1'b0, {(ACC_WIDTH-1){1'b1}}});
      if (s > mx) s = mx;
      if (s < -mx - 1) s = -mx - 1;
      sat_add = s[ACC_WIDTH-1:0];
    end
  endfunction

  assign n = (tap_count > 7'(TAPS)) ? (TAP_BITS+1)'(TAPS) : (TAP_BITS+1)'(tap_count);
  assign c_addr = idx[TAP_BITS-1:0];
  assign d_addr = k[TAP_BITS-1:0];
  assign busy = state != S_IDLE || q_valid;
  assign q_pop = state == S_IDLE && q_valid;
  assign last_phase = 5'(phase) + 5'd1 >= 5'(job.phases);
  assign m_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_v <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      mul_v <= rd_v;
      rd_v <= 1'b0;
      if (mul_v && state != S_IDLE) begin
        acc_re <= sat_add(acc_re, p_re);
        acc_im <= sat_add(acc_im, p_im);
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job <= q_job;
            phase <= '0;
            idx <= '0;
            k <= '0;
            acc_re <= '0;
            acc_im <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (idx < n) begin
            rd_v <= 1'b1;
            idx <= idx + (TAP_BITS+1)'(job.step);
            k <= k + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !mul_v) begin
            m_data <= {last_phase, finish(acc_im, output_shift),
                       finish(acc_re, output_shift)};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_ready) begin
            acc_re <= '0;
            acc_im <= '0;
            k <= '0;
            idx <= (TAP_BITS+1)'(phase) + 1'b1;
            phase <= phase + 1'b1;
            state <= last_phase ? S_IDLE : S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_re <= PROD_WIDTH'(signed'(d_data[SAMPLE_WIDTH-1:0])) *
            PROD_WIDTH'(signed'(c_data));
    p_im <= PROD_WIDTH'(signed'(d_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])) *
            PROD_WIDTH'(signed'(c_data));
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |=> state == S_RUN)
    else $error("job pop did not start run");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_valid && !m_ready |=> m_valid && $stable(m_data))
    else $error("result changed while stalled");
  a_no_mul_out: assert property (@(posedge clk) disable iff (rst) m_valid |-> !mul_v)
    else $error("product pending during output");
endmodule
`default_nettype wire

// ----- src/polyphase_complex_fir_filter.sv -----
// top level: apb registers, delay and coefficient memories, front and back ends
// each output phase: run over the taps at the job's step, drain the mac pipeline, hold the result
// jobs: one per sample, or one per group of samples when decimating; each job gives one output per phase
// the single mac pair over the coefficient and delay memories serves every phase in turn
// every request, coefficient writes too, waits until the back end is idle
// reset: synchronous, registers return to rate 1, 64 taps, shift 15
// reset clears memories by a clearing pass during which no item is taken
`timescale 1ns / 1ps
`default_nettype none
module polyphase_complex_fir_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cmd, then sample_re, sample_im, coeff_index, coeff_value, from bit 0; zero padded
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_re, out_im from bit 0
  output logic [31:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pcf_pkg::*;
  logic signed [5:0] rate_change;
  logic [6:0] tap_count;
  logic [5:0] output_shift;
  logic [TAP_BITS:0] clr;
  logic clearing;
  logic f_ready, q_full, q_push, q_valid, q_pop, back_busy, coef_we, dly_we;
  job_t job_in, job_q;
  logic [TAP_BITS-1:0] c_addr, d_addr, head, dw_addr, cw_addr;
  logic [COEFF_WIDTH-1:0] c_data, cw_data;
  logic [2*SAMPLE_WIDTH-1:0] d_data, dw_data;
  logic [2*OUT_WIDTH:0] m_data;
  logic [1:0] reg_sel;
  logic cmd;

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_change <= 6'sd1;
      tap_count <= 7'd64;
      output_shift <= 6'd15;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_RATE: rate_change <= pwdata[5:0];
        REG_TAPS: tap_count <= pwdata[6:0];
        REG_SHIFT: output_shift <= pwdata[5:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_sel)
      REG_RATE: prdata = {26'd0, rate_change};
      REG_TAPS: prdata = {25'd0, tap_count};
      REG_SHIFT: prdata = {26'd0, output_shift};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      head <= '0;
    end else begin
      if (clearing) clr <= clr + 1'b1;
      if (dly_we) head <= head - 1'b1;
    end
  end
  assign clearing = !clr[TAP_BITS];
  assign cmd = s_tdata[0];
  assign s_tready = f_ready && !clearing;

  pcf_front u_front (
    .clk, .rst, .in_valid(s_tvalid && !clearing), .in_ready(f_ready), .cmd,
    .back_busy, .q_full, .q_push, .q_job(job_in), .coef_we, .dly_we, .rate_change
  );

  // short job queue, depth one
  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (q_push) q_valid <= 1'b1;
    else if (q_pop) q_valid <= 1'b0;
    if (q_push) job_q <= job_in;
  end
  assign q_full = q_valid;

  assign cw_addr = clearing ? clr[TAP_BITS-1:0] : s_tdata[38:33];
  assign cw_data = clearing ? '0 : s_tdata[54:39];
  assign dw_addr = clearing ? clr[TAP_BITS-1:0] : head - 1'b1;
  assign dw_data = clearing ? '0 : s_tdata[32:1];

  pcf_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(TAPS)) u_coef (
    .clk, .we(clearing || coef_we), .waddr(cw_addr), .wdata(cw_data),
    .raddr(c_addr), .rdata(c_data)
  );
  pcf_ram #(.WIDTH(2*SAMPLE_WIDTH), .DEPTH(TAPS)) u_delay (
    .clk, .we(clearing || dly_we), .waddr(dw_addr), .wdata(dw_data),
    .raddr(head + d_addr), .rdata(d_data)
  );

  pcf_back u_back (
    .clk, .rst, .q_valid, .q_job(job_q), .q_pop, .busy(back_busy), .tap_count,
    .output_shift, .c_addr, .d_addr, .c_data, .d_data, .m_valid(m_tvalid),
    .m_ready(m_tready), .m_data
  );
  assign m_tdata = m_data[2*OUT_WIDTH-1:0];
  assign m_tlast = m_data[2*OUT_WIDTH];

  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("request taken during clearing pass");
  a_push_free: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_valid)
    else $error("job queue overflow");
  a_sample_idle: assert property (@(posedge clk) disable iff (rst) dly_we |-> !back_busy)
    else $error("delay written while in use");
endmodule
`default_nettype wire
